### rtl/sgc_pkg.sv
package sgc_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 29;

  localparam logic [CFG_IDX_W-1:0] CFG_FB_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_W    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_H    = 2'd2;

  localparam logic [28:0] FB_BYTES_RST = 29'd0;
  localparam logic [15:0] MAX_W_RST    = 16'd4096;
  localparam logic [15:0] MAX_H_RST    = 16'd4096;

  localparam logic [7:0] DEPTH_8  = 8'd8;
  localparam logic [7:0] DEPTH_15 = 8'd15;
  localparam logic [7:0] DEPTH_16 = 8'd16;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  localparam logic [2:0] BPP_NONE = 3'd0;
  localparam logic [2:0] BPP_1    = 3'd1;
  localparam logic [2:0] BPP_2    = 3'd2;
  localparam logic [2:0] BPP_3    = 3'd3;
  localparam logic [2:0] BPP_4    = 3'd4;

  // remainder steps: 16 quotient bits cover every start row that can pass
  localparam int DIV_STEPS = 16;
  localparam int FRONT_STAGES = 3;
  localparam int NUM_STAGES = FRONT_STAGES + DIV_STEPS;

  typedef struct packed {
    logic        mode;
    logic [31:0] byte_offset;
    logic [31:0] row_pitch;
    logic [31:0] pixel_width;
    logic [31:0] pixel_height;
    logic [7:0]  depth_bits;
  } in_item_t;

  typedef struct packed {
    logic       valid_res;
    logic [2:0] bytes_per_pixel;
  } out_item_t;

  typedef struct packed {
    logic        mode;
    logic [2:0]  bpp;
    logic        fail;
    logic [31:0] off;
    logic [31:0] pitch;
    logic [31:0] hgt;
    logic [31:0] row;
    logic [5:0]  off_sum;
    logic [5:0]  pitch_sum;
    logic [28:0] slack;
    logic [63:0] span;
    logic [31:0] rem;
  } ctx_t;

  function automatic logic [2:0] depth_to_bpp(input logic [7:0] depth);
    logic [2:0] b;
    unique case (depth)
      DEPTH_8:            b = BPP_1;
      DEPTH_15, DEPTH_16: b = BPP_2;
      DEPTH_24:           b = BPP_3;
      DEPTH_32:           b = BPP_4;
      default:            b = BPP_NONE;
    endcase
    return b;
  endfunction

  // base-4 digit sum, congruent to the value modulo 3
  function automatic logic [5:0] digit_sum4(input logic [31:0] v);
    logic [5:0] s;
    s = 6'd0;
    for (int i = 0; i < 16; i++) begin
      s = s + 6'(v[2*i +: 2]);
    end
    return s;
  endfunction

  function automatic logic div3(input logic [5:0] v);
    logic [3:0] s;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]);
    return (s == 4'd0) || (s == 4'd3) || (s == 4'd6) || (s == 4'd9);
  endfunction

endpackage

### rtl/surface_geometry_checker.sv
// throughput: one item per cycle unless the output stalls; the 16-step remainder
// pipeline takes one stage per step, the 32x32 span multiplier a single stage
// reset: rst_n low clears all stage valid bits and sets the registers to
// framebuffer_bytes 0, max_scanout_width 4096, max_scanout_height 4096
module surface_geometry_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  sgc_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sgc_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [sgc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sgc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import sgc_pkg::*;

  logic [28:0] fb_bytes_r;
  logic [15:0] max_w_r;
  logic [15:0] max_h_r;

  ctx_t ctx_r   [NUM_STAGES];
  ctx_t ctx_nxt [NUM_STAGES];
  logic [NUM_STAGES-1:0] vld_r;
  out_item_t res_r, res_nxt;
  logic res_vld_r;
  logic adv;

  assign adv = !res_vld_r || out_ready;
  assign in_ready = adv;
  assign out_valid = res_vld_r;
  assign out_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_bytes_r <= FB_BYTES_RST;
      max_w_r <= MAX_W_RST;
      max_h_r <= MAX_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FB_BYTES: fb_bytes_r <= cfg_wdata;
        CFG_MAX_W:    max_w_r <= cfg_wdata[15:0];
        CFG_MAX_H:    max_h_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [34:0] row_w;
    logic [2:0]  b;
    logic        scan_fail;
    logic        align_fail;
    logic [28:0] left;
    logic [47:0] dsh;
    ctx_t c;

    // stage 0: depth decode, row bytes, scanout limits, digit sums
    b = depth_to_bpp(in_data.depth_bits);
    row_w = 35'(in_data.pixel_width) * 35'(b);
    scan_fail = in_data.mode && (
      (in_data.pixel_width > 32'(max_w_r)) ||
      (in_data.pixel_height > 32'(max_h_r)) ||
      (in_data.row_pitch >= {13'd0, b, 16'd0}) ||
      ({16'd0, in_data.byte_offset} >= {in_data.row_pitch, 16'd0}));
    c = '0;
    c.mode = in_data.mode;
    c.bpp = b;
    c.fail = scan_fail || (b == BPP_NONE) || (in_data.pixel_width == 32'd0) ||
             (in_data.pixel_height == 32'd0) || (in_data.row_pitch == 32'd0) ||
             (row_w[34:32] != 3'd0);
    c.off = in_data.byte_offset;
    c.pitch = in_data.row_pitch;
    c.hgt = in_data.pixel_height - 32'd1;
    c.row = row_w[31:0];
    c.off_sum = digit_sum4(in_data.byte_offset);
    c.pitch_sum = digit_sum4(in_data.row_pitch);
    ctx_nxt[0] = c;

    // stage 1: alignment and video memory bounds
    c = ctx_r[0];
    case (c.bpp)
      BPP_2:   align_fail = c.off[0] || c.pitch[0];
      BPP_3:   align_fail = !div3(c.off_sum) || !div3(c.pitch_sum);
      BPP_4:   align_fail = (c.off[1:0] != 2'd0) || (c.pitch[1:0] != 2'd0);
      default: align_fail = 1'b0;
    endcase
    left = fb_bytes_r - c.off[28:0];
    c.fail = c.fail || align_fail || (c.row > c.pitch) ||
             (c.off > 32'(fb_bytes_r)) || (c.row > 32'(left));
    c.slack = left - c.row[28:0];
    ctx_nxt[1] = c;

    // stage 2: bytes spanned by the rows after the first
    c = ctx_r[1];
    c.span = 64'(c.hgt) * 64'(c.pitch);
    c.rem = c.off;
    ctx_nxt[2] = c;

    // remainder of offset by pitch, one quotient bit per stage
    for (int k = 0; k < DIV_STEPS; k++) begin
      c = ctx_r[FRONT_STAGES-1+k];
      dsh = 48'(c.pitch) << (DIV_STEPS-1-k);
      if ({16'd0, c.rem} >= dsh) begin
        c.rem = c.rem - dsh[31:0];
      end
      ctx_nxt[FRONT_STAGES+k] = c;
    end

    c = ctx_r[NUM_STAGES-1];
    res_nxt.bytes_per_pixel = c.bpp;
    res_nxt.valid_res = !c.fail && !(c.span > 64'(c.slack)) &&
                        !(c.mode && ((33'(c.rem) + 33'(c.row)) > 33'(c.pitch)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      res_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_valid};
      res_vld_r <= vld_r[NUM_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        ctx_r[i] <= ctx_nxt[i];
      end
      res_r <= res_nxt;
    end
  end

endmodule

### rtl/sgc_checker.sv
module sgc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input sgc_pkg::out_item_t out_data
);
  import sgc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> in_ready)
    else $error("input blocked while result drains");

  // unsupported depth can never pass
  a_bad_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.bytes_per_pixel == BPP_NONE) |-> !out_data.valid_res)
    else $error("unsupported depth marked valid");

endmodule

bind surface_geometry_checker sgc_checker u_sgc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);
